>>> src/c2gb_pkg.sv
// Shared types and constants for the CIGAR-to-gapless-block converter.
// No dependencies; imported by every module of the block.
package c2gb_pkg;

    localparam int FIELD_W = 48;   // external coordinate and length width
    localparam int NAME_W  = 64;   // sequence name width
    localparam int OPLEN_W = 32;   // cigar op length width
    localparam int TRIM_W  = 31;   // trim register width

    // Item selector carried in tuser
    localparam logic FUNC_HDR = 1'b0;
    localparam logic FUNC_OP  = 1'b1;

    typedef enum logic [1:0] {
        OP_MATCH  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_kind_t;

    // One input transaction after unpacking
    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] qry_begin;
        logic [FIELD_W-1:0] qry_finish;
        logic [FIELD_W-1:0] tgt_begin;
        logic               forward_strand;
        logic [NAME_W-1:0]  query_id;
        logic [NAME_W-1:0]  target_id;
        logic [1:0]         op_kind;
        logic [OPLEN_W-1:0] op_length;
        logic               last_op;
    } item_t;

    // Alignment identity attached to a closed run
    typedef struct packed {
        logic [NAME_W-1:0] query_id;
        logic [NAME_W-1:0] target_id;
        logic              forward;
    } run_tag_t;

endpackage

>>> src/cigar_to_gapless_blocks_unit.sv
// Pipeline: a result passes through the input register, the core's record register
//   and the trim/result register.
// Throughput: one transaction per cycle unless back-pressure holds a record in the core
//   or trim stage; the core computes the next coordinates and run total combinationally.
// Reset (rst_n low, async): coordinates, run state and names clear, strand forward, trim 0.
module cigar_to_gapless_blocks_unit
    import c2gb_pkg::*;
#(
    parameter int COORD_BITS = 48   // running coordinate width, 16..63
)
(
    input  logic         clk,
    input  logic         rst_n,

    // Configuration: trim amount, written when cfg_we is high
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata,     // trim_amount

    // Slave side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [47:0] qry_begin, [95:48] qry_finish, [143:96] tgt_begin,
    // [144] forward_strand, [208:145] query_id, [272:209] target_id,
    // [304:273] op_length, [311:305] zero
    input  logic [311:0] s_axis_tdata,
    // [0] func, [2:1] op_kind
    input  logic [2:0]   s_axis_tuser,
    input  logic         s_axis_tlast,  // last_op

    // Master side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] out_query_id, [127:64] out_target_id, [175:128] out_query_pos,
    // [223:176] out_target_pos, [271:224] out_length, [272] out_forward,
    // [279:273] zero
    output logic [279:0] m_axis_tdata
);

    logic [TRIM_W-1:0] trim_reg;

    item_t s_item;
    item_t a_item;
    logic  a_valid;
    logic  a_ready;

    logic                  rec_valid;
    logic                  rec_ready;
    logic [COORD_BITS-1:0] rec_qstart, rec_tstart, rec_total;
    run_tag_t              rec_tag;

    run_tag_t           res_tag;
    logic [FIELD_W-1:0] res_qpos, res_tpos, res_length;

    // Trim register; the user must change configuration only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= '0;
        end
        else if (cfg_we)
        begin
            trim_reg <= cfg_wdata;
        end
    end

    // Unpack the slave transaction
    always_comb
    begin
        s_item.func           = s_axis_tuser[0];
        s_item.op_kind        = s_axis_tuser[2:1];
        s_item.qry_begin      = s_axis_tdata[47:0];
        s_item.qry_finish     = s_axis_tdata[95:48];
        s_item.tgt_begin      = s_axis_tdata[143:96];
        s_item.forward_strand = s_axis_tdata[144];
        s_item.query_id       = s_axis_tdata[208:145];
        s_item.target_id      = s_axis_tdata[272:209];
        s_item.op_length      = s_axis_tdata[304:273];
        s_item.last_op        = s_axis_tlast;
    end

    c2gb_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (s_item),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_item  (a_item)
    );

    // Header / cigar op interpreter holding the running coordinates
    c2gb_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (a_valid),
        .item_ready (a_ready),
        .item       (a_item),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_qstart (rec_qstart),
        .rec_tstart (rec_tstart),
        .rec_total  (rec_total),
        .rec_tag    (rec_tag)
    );

    // Trim, filter and output register
    c2gb_trim #(
        .COORD_BITS (COORD_BITS)
    ) u_trim (
        .clk        (clk),
        .rst_n      (rst_n),
        .trim       (trim_reg),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_qstart (rec_qstart),
        .rec_tstart (rec_tstart),
        .rec_total  (rec_total),
        .rec_tag    (rec_tag),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_tag    (res_tag),
        .res_qpos   (res_qpos),
        .res_tpos   (res_tpos),
        .res_length (res_length)
    );

    // Pack the master transaction
    assign m_axis_tdata = {7'd0, res_tag.forward, res_length, res_tpos, res_qpos,
                           res_tag.target_id, res_tag.query_id};

endmodule

>>> src/c2gb_in_reg.sv
// Input register stage: holds one accepted transaction for the core.
// Depends on c2gb_pkg.
module c2gb_in_reg
    import c2gb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> src/c2gb_core.sv
// Running-coordinate core: applies one header or cigar op per cycle if
// not stalled; issues a record when a run ends. Depends on c2gb_pkg.
module c2gb_core
    import c2gb_pkg::*;
#(
    parameter int COORD_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  rec_valid,
    input  logic                  rec_ready,
    output logic [COORD_BITS-1:0] rec_qstart,
    output logic [COORD_BITS-1:0] rec_tstart,
    output logic [COORD_BITS-1:0] rec_total,
    output run_tag_t              rec_tag
);

    logic [COORD_BITS-1:0] qpos_reg, qpos_next;
    logic [COORD_BITS-1:0] tpos_reg, tpos_next;
    logic [COORD_BITS-1:0] run_total_reg, run_total_next;
    logic                  in_run_reg, in_run_next;
    logic                  strand_reg, strand_next;
    logic [NAME_W-1:0]     qname_reg, qname_next;
    logic [NAME_W-1:0]     tname_reg, tname_next;

    logic                  rec_valid_reg;
    logic [COORD_BITS-1:0] rec_qstart_reg, rec_tstart_reg, rec_total_reg;
    run_tag_t              rec_tag_reg;

    logic                  slot_free;
    logic                  step;
    logic [COORD_BITS-1:0] len_c;
    logic                  is_op;
    logic                  is_match;
    logic                  close_c;
    logic [COORD_BITS-1:0] total_c;
    logic [COORD_BITS-1:0] qpos_fwd, qpos_rev, qpos_after, tpos_after;

    assign slot_free  = !rec_valid_reg || rec_ready;
    assign item_ready = slot_free;
    assign step       = item_valid && slot_free;

    assign rec_valid  = rec_valid_reg;
    assign rec_qstart = rec_qstart_reg;
    assign rec_tstart = rec_tstart_reg;
    assign rec_total  = rec_total_reg;
    assign rec_tag    = rec_tag_reg;

    always_comb
    begin
        len_c    = COORD_BITS'(item.op_length);
        is_op    = (item.func == FUNC_OP);
        is_match = is_op && (item.op_kind == OP_MATCH);
        // a match extends the open run before any close
        total_c  = is_match ? (run_total_reg + len_c) : run_total_reg;
        close_c  = is_match ? item.last_op : in_run_reg;

        qpos_fwd   = qpos_reg + total_c;
        qpos_rev   = qpos_reg - total_c;
        qpos_after = !close_c ? qpos_reg : (strand_reg ? qpos_fwd : qpos_rev);
        tpos_after = close_c ? (tpos_reg + total_c) : tpos_reg;

        qpos_next      = qpos_after;
        tpos_next      = tpos_after;
        run_total_next = '0;
        in_run_next    = 1'b0;
        strand_next    = strand_reg;
        qname_next     = qname_reg;
        tname_next     = tname_reg;

        if (!is_op)
        begin
            // header: reverse strand walks down from the query end
            strand_next = item.forward_strand;
            qpos_next   = COORD_BITS'(item.forward_strand ? item.qry_begin
                                                          : item.qry_finish);
            tpos_next   = COORD_BITS'(item.tgt_begin);
            qname_next  = item.query_id;
            tname_next  = item.target_id;
        end
        else
        begin
            unique case (item.op_kind)
                OP_MATCH:
                begin
                    run_total_next = close_c ? '0 : total_c;
                    in_run_next    = !close_c;
                end
                OP_INSERT:
                begin
                    qpos_next = strand_reg ? (qpos_after + len_c)
                                           : (qpos_after - len_c);
                end
                OP_DELETE:
                begin
                    tpos_next = tpos_after + len_c;
                end
                default:
                begin
                    // unknown op only closes the open run
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg      <= '0;
            tpos_reg      <= '0;
            run_total_reg <= '0;
            in_run_reg    <= 1'b0;
            strand_reg    <= 1'b1;
            qname_reg     <= '0;
            tname_reg     <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                qpos_reg      <= qpos_next;
                tpos_reg      <= tpos_next;
                run_total_reg <= run_total_next;
                in_run_reg    <= in_run_next;
                strand_reg    <= strand_next;
                qname_reg     <= qname_next;
                tname_reg     <= tname_next;
            end
            if (slot_free)
            begin
                rec_valid_reg <= step && close_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && close_c)
        begin
            rec_qstart_reg      <= strand_reg ? qpos_reg : qpos_rev;
            rec_tstart_reg      <= tpos_reg;
            rec_total_reg       <= total_c;
            rec_tag_reg.query_id  <= qname_reg;
            rec_tag_reg.target_id <= tname_reg;
            rec_tag_reg.forward   <= strand_reg;
        end
    end

`ifndef SYNTH
    a_hdr_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !is_op) |=> (!in_run_reg && run_total_reg == '0))
        else $error("header left a run open");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_match && item.last_op) |=> !in_run_reg)
        else $error("last match op did not close the run");

    a_run_opens_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_run_reg) |-> $past(step && is_match))
        else $error("run opened without a match op");
`endif

endmodule

>>> src/c2gb_trim.sv
// Trim stage: applies the configured trim to a closed run, drops short
// blocks and holds the result register. Depends on c2gb_pkg.
module c2gb_trim
    import c2gb_pkg::*;
#(
    parameter int COORD_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [TRIM_W-1:0]     trim,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  logic [COORD_BITS-1:0] rec_qstart,
    input  logic [COORD_BITS-1:0] rec_tstart,
    input  logic [COORD_BITS-1:0] rec_total,
    input  run_tag_t              rec_tag,
    output logic                  res_valid,
    input  logic                  res_ready,
    output run_tag_t              res_tag,
    output logic [FIELD_W-1:0]    res_qpos,
    output logic [FIELD_W-1:0]    res_tpos,
    output logic [FIELD_W-1:0]    res_length
);

    localparam int CMP_W = (COORD_BITS > TRIM_W + 1) ? COORD_BITS : TRIM_W + 1;

    logic               res_valid_reg;
    run_tag_t           res_tag_reg;
    logic [FIELD_W-1:0] res_qpos_reg, res_tpos_reg, res_length_reg;

    logic [CMP_W-1:0]      total_w, twice_w, diff_w;
    logic [COORD_BITS-1:0] trim_c, qpos_c, tpos_c;
    logic                  keep;

    assign rec_ready  = !res_valid_reg || res_ready;
    assign res_valid  = res_valid_reg;
    assign res_tag    = res_tag_reg;
    assign res_qpos   = res_qpos_reg;
    assign res_tpos   = res_tpos_reg;
    assign res_length = res_length_reg;

    always_comb
    begin
        total_w = CMP_W'(rec_total);
        twice_w = CMP_W'({trim, 1'b0});
        keep    = total_w > twice_w;
        diff_w  = total_w - twice_w;
        trim_c  = COORD_BITS'(trim);
        qpos_c  = rec_qstart + trim_c;
        tpos_c  = rec_tstart + trim_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rec_ready)
        begin
            res_valid_reg <= rec_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_ready && rec_valid)
        begin
            res_tag_reg    <= rec_tag;
            res_qpos_reg   <= FIELD_W'(qpos_c);
            res_tpos_reg   <= FIELD_W'(tpos_c);
            res_length_reg <= FIELD_W'(diff_w);
        end
    end

`ifndef SYNTH
    a_len_positive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_length_reg != '0))
        else $error("zero-length block emitted");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for cigar_to_gapless_blocks_unit: directed and random
// alignment streams, a scoreboard class that predicts the gapless blocks.
// Depends on src/c2gb_pkg.sv and src/cigar_to_gapless_blocks_unit.sv.
module tb_top;
    import c2gb_pkg::*;

    localparam int          RUN_LIMIT = 1_000_000;  // cycles before the run is called hung
    localparam int          DRAIN_CYC = 8;          // wait for the pipeline registers to empty, with margin
    localparam int          IDLE_PCT  = 22;
    localparam logic [1:0]  OP_UNUSED = 2'd3;       // op kind with no meaning: just closes a run
    localparam logic [30:0] TRIM_MAX  = 31'h7FFF_FFFF;

    // One emitted gapless block, field for field
    typedef struct packed {
        logic [NAME_W-1:0]  query_id;
        logic [NAME_W-1:0]  target_id;
        logic [FIELD_W-1:0] query_pos;
        logic [FIELD_W-1:0] target_pos;
        logic [FIELD_W-1:0] length;
        logic               forward;
    } block_t;

    // Tracks the running alignment coordinates and queues the blocks the
    // block should produce; checks each output transaction against them.
    class block_scoreboard;
        logic [TRIM_W-1:0]  trim;
        logic [FIELD_W-1:0] q_coord;
        logic [FIELD_W-1:0] t_coord;
        logic [FIELD_W-1:0] run_len;
        bit                 run_open;
        bit                 fwd;
        logic [NAME_W-1:0]  q_name;
        logic [NAME_W-1:0]  t_name;
        block_t             blocks_due[$];
        int                 errors;

        function new();
            trim     = '0;
            q_coord  = '0;
            t_coord  = '0;
            run_len  = '0;
            run_open = 0;
            fwd      = 1;
            q_name   = '0;
            t_name   = '0;
            errors   = 0;
        endfunction

        function void set_trim(logic [TRIM_W-1:0] v);
            trim = v;
        endfunction

        // End the open run: move coordinates, queue a block if it survives trim
        function void end_run();
            logic [FIELD_W-1:0] q_first;
            logic [FIELD_W-1:0] twice;
            block_t             b;
            if (!run_open)
                return;
            if (fwd)
            begin
                q_first = q_coord;
                q_coord = q_coord + run_len;
            end
            else
            begin
                // reverse strand: block starts at the coordinate after moving down
                q_coord = q_coord - run_len;
                q_first = q_coord;
            end
            twice = FIELD_W'(trim) << 1;
            if (run_len > twice)
            begin
                b.query_id   = q_name;
                b.target_id  = t_name;
                b.query_pos  = q_first + FIELD_W'(trim);
                b.target_pos = t_coord + FIELD_W'(trim);
                b.length     = run_len - twice;
                b.forward    = fwd;
                blocks_due.push_back(b);
            end
            t_coord  = t_coord + run_len;
            run_len  = '0;
            run_open = 0;
        endfunction

        function void note_item(item_t it);
            logic [FIELD_W-1:0] len;
            len = FIELD_W'(it.op_length);
            if (it.func == FUNC_HDR)
            begin
                end_run();  // an open run goes out under the old names
                fwd     = it.forward_strand;
                q_coord = fwd ? it.qry_begin : it.qry_finish;
                t_coord = it.tgt_begin;
                q_name  = it.query_id;
                t_name  = it.target_id;
                run_len = '0;
                run_open = 0;
            end
            else if (it.op_kind == OP_MATCH)
            begin
                run_len  = run_len + len;
                run_open = 1;
                if (it.last_op)
                    end_run();
            end
            else
            begin
                end_run();
                if (it.op_kind == OP_INSERT)
                    q_coord = fwd ? q_coord + len : q_coord - len;
                else if (it.op_kind == OP_DELETE)
                    t_coord = t_coord + len;
            end
        endfunction

        function void check_block(logic [279:0] d);
            block_t want;
            block_t got;
            got.query_id   = d[63:0];
            got.target_id  = d[127:64];
            got.query_pos  = d[175:128];
            got.target_pos = d[223:176];
            got.length     = d[271:224];
            got.forward    = d[272];
            if (blocks_due.size() == 0)
            begin
                $error("unexpected output block: query_id %h length %h",
                       got.query_id, got.length);
                errors++;
                return;
            end
            want = blocks_due.pop_front();
            if (got.query_id !== want.query_id)
            begin
                $error("out_query_id: expected %h, got %h", want.query_id, got.query_id);
                errors++;
            end
            if (got.target_id !== want.target_id)
            begin
                $error("out_target_id: expected %h, got %h", want.target_id, got.target_id);
                errors++;
            end
            if (got.query_pos !== want.query_pos)
            begin
                $error("out_query_pos: expected %h, got %h", want.query_pos, got.query_pos);
                errors++;
            end
            if (got.target_pos !== want.target_pos)
            begin
                $error("out_target_pos: expected %h, got %h", want.target_pos, got.target_pos);
                errors++;
            end
            if (got.length !== want.length)
            begin
                $error("out_length: expected %h, got %h", want.length, got.length);
                errors++;
            end
            if (got.forward !== want.forward)
            begin
                $error("out_forward: expected %b, got %b", want.forward, got.forward);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [30:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [311:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [279:0] m_axis_tdata;

    block_scoreboard sb;
    item_t           held_item;     // unpacked copy of what is on the slave bus
    bit              burst;         // set: neither side idles
    int              items_sent;
    int              cycles;

    cigar_to_gapless_blocks_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random backpressure, none while in burst
    always @(negedge clk)
        m_axis_tready <= burst || ($urandom_range(99) >= IDLE_PCT);

    // Both monitors in one block so result checks come before new predictions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_block(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(held_item);
        end
    end

    function automatic logic [FIELD_W-1:0] rand_coord();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    function automatic logic [OPLEN_W-1:0] rand_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(1, 60);
        if (pick < 90)
            return $urandom_range(1, 65535);
        return $urandom;    // full range, zero included
    endfunction

    // Every field random; callers overwrite what matters
    function automatic item_t rand_item();
        item_t it;
        it.func           = 1'($urandom_range(1));
        it.qry_begin      = rand_coord();
        it.qry_finish     = rand_coord();
        it.tgt_begin      = rand_coord();
        it.forward_strand = 1'($urandom_range(1));
        it.query_id       = {$urandom, $urandom};
        it.target_id      = {$urandom, $urandom};
        it.op_kind        = 2'($urandom_range(3));
        it.op_length      = $urandom;
        it.last_op        = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic item_t mk_hdr(logic fwd, logic [FIELD_W-1:0] qs, logic [FIELD_W-1:0] qe,
                                     logic [FIELD_W-1:0] ts, logic [NAME_W-1:0] qid,
                                     logic [NAME_W-1:0] tid);
        item_t it;
        it                = rand_item();
        it.func           = FUNC_HDR;
        it.forward_strand = fwd;
        it.qry_begin      = qs;
        it.qry_finish     = qe;
        it.tgt_begin      = ts;
        it.query_id       = qid;
        it.target_id      = tid;
        return it;
    endfunction

    function automatic item_t mk_op(logic [1:0] kind, logic [OPLEN_W-1:0] len, logic last);
        item_t it;
        it           = rand_item();
        it.func      = FUNC_OP;
        it.op_kind   = kind;
        it.op_length = len;
        it.last_op   = last;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input item_t it);
        while (!burst && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, it.op_length, it.target_id, it.query_id, it.forward_strand,
                          it.tgt_begin, it.qry_finish, it.qry_begin};
        s_axis_tuser  <= {it.op_kind, it.func};
        s_axis_tlast  <= it.last_op;
        held_item     <= it;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // Drain every expected block, let the pipe empty, then load a new trim
    task automatic write_trim(input logic [TRIM_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (sb.blocks_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_trim(v);
    endtask

    // Well-formed alignment: header, then 1..12 ops with last_op on the final one
    task automatic send_alignment();
        int    n_ops;
        int    pick;
        item_t it;
        it      = rand_item();
        it.func = FUNC_HDR;
        send_item(it);
        n_ops = $urandom_range(1, 12);
        for (int i = 0; i < n_ops; i++)
        begin
            pick = $urandom_range(99);
            it   = mk_op(pick < 60 ? OP_MATCH : pick < 78 ? OP_INSERT :
                         pick < 97 ? OP_DELETE : OP_UNUSED,
                         rand_len(), i == n_ops - 1);
            send_item(it);
        end
    endtask

    initial
    begin
        logic [TRIM_W-1:0] phase_trim [5];
        int                goal;

        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        held_item     = '0;
        burst         = 0;
        items_sent    = 0;
        cycles        = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- Directed part ----
        write_trim('0);
        // ops before any header run on the reset state
        send_item(mk_op(OP_MATCH, 32'd5, 1'b0));
        send_item(mk_op(OP_MATCH, 32'd3, 1'b1));
        // coordinates at the top of the range, so they wrap
        send_item(mk_hdr(1'b1, 48'hFFFF_FFFF_FFF0, '0, 48'hFFFF_FFFF_FFFF, '1, '0));
        send_item(mk_op(OP_MATCH, 32'hFFFF_FFFF, 1'b0));
        send_item(mk_op(OP_INSERT, 32'd10, 1'b0));          // closes the run
        send_item(mk_op(OP_DELETE, 32'hFFFF_FFFF, 1'b0));
        send_item(mk_op(OP_UNUSED, 32'd77, 1'b0));          // nothing open
        send_item(mk_op(OP_MATCH, 32'd7, 1'b0));
        send_item(mk_op(OP_UNUSED, 32'd99, 1'b0));          // closes the open run
        send_item(mk_op(OP_MATCH, 32'd0, 1'b1));            // zero-length run, dropped
        send_item(mk_op(OP_MATCH, 32'd4, 1'b0));
        send_item(mk_op(OP_DELETE, 32'd2, 1'b1));           // last_op on a non-match
        send_item(mk_op(OP_MATCH, 32'd6, 1'b0));
        // header with a run still open: old run goes out under old names
        send_item(mk_hdr(1'b0, 48'd1, 48'd2, '0, '0, '1));
        send_item(mk_op(OP_MATCH, 32'd1, 1'b0));
        send_item(mk_op(OP_INSERT, 32'd5, 1'b0));           // reverse: moves below zero
        send_item(mk_op(OP_MATCH, 32'd3, 1'b1));
        // largest trim: only a run longer than twice the trim survives
        write_trim(TRIM_MAX);
        send_item(mk_hdr(1'b1, '0, '0, '0, 64'd1, 64'd2));
        send_item(mk_op(OP_MATCH, 32'hFFFF_FFFF, 1'b1));    // length 1 after trim
        send_item(mk_op(OP_MATCH, 32'hFFFF_FFFE, 1'b1));    // exactly twice the trim
        write_trim(31'd5);
        send_item(mk_hdr(1'b0, 48'd100, 48'd200, 48'd300, 64'd3, 64'd4));
        send_item(mk_op(OP_MATCH, 32'd10, 1'b1));           // trimmed to zero
        send_item(mk_op(OP_MATCH, 32'd11, 1'b1));

        // ---- Random part: five trim settings, one phase with no idling ----
        phase_trim[0] = '0;
        phase_trim[1] = TRIM_W'($urandom_range(1, 8));
        phase_trim[2] = TRIM_MAX;
        phase_trim[3] = TRIM_W'($urandom_range(1, 40));
        phase_trim[4] = TRIM_W'($urandom);
        for (int p = 0; p < 5; p++)
        begin
            write_trim(phase_trim[p]);
            burst = (p == 1);
            goal  = items_sent + 100;
            while (items_sent < goal)
            begin
                if ($urandom_range(99) < 85)
                    send_alignment();
                else
                    send_item(rand_item());     // noise and broken sequences
            end
        end
        burst = 0;

        // ---- Drain ----
        s_axis_tvalid <= 1'b0;
        while (sb.blocks_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (sb.errors == 0 && sb.blocks_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
